// ===== rtl/uld_pkg.sv =====
// Package for the UTF-8 ligature decoder: item kinds, status codes, table
// entry types and the byte-window helper used by the top level.
// No dependencies.
`timescale 1ns / 1ps
package uld_pkg;

    localparam int WINDOW_BYTES    = 8;
    localparam int NUM_LIGS_DEF    = 32;
    localparam int MAX_LIG_LEN_DEF = 4;

    localparam logic [7:0] TAG3_LO   = 8'h17;
    localparam logic [7:0] TAG3_HI   = 8'h1e;
    localparam logic [7:0] TAG2      = 8'h1f;
    localparam logic [7:0] BAR       = 8'h7c;
    localparam logic [7:0] ZWNJ_B0   = 8'he2;
    localparam logic [7:0] ZWNJ_B1   = 8'h80;
    localparam logic [7:0] ZWNJ_B2   = 8'h8c;
    localparam logic [7:0] LEAD3_LO  = 8'he0;
    localparam logic [7:0] LEAD4_LO  = 8'hf0;
    localparam logic [7:0] ASCII_MAX = 8'h7f;
    localparam logic [20:0] ZWNJ_CP  = 21'h00200c;

    typedef enum logic [1:0] {
        K_DECODE = 2'd0,
        K_ADD    = 2'd1,
        K_DEL    = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LEADCONT = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD      = 2'd3
    } t_status;

    typedef struct packed {
        logic        valid;
        logic [2:0]  len;
        logic [31:0] text;
        logic [15:0] code;
    } t_entry;

    typedef struct packed {
        logic [2:0]  len;
        logic [15:0] code;
    } t_hit;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        t_kind       kind;
        logic        commit;
        logic        len_ok;
        logic        ins;
        logic [2:0]  llen;
        logic [31:0] text;
        logic [15:0] lout;
        logic [31:0] look;
    } t_cell_ctl;

    // Byte of the window at idx; positions past the window read as zero.
    function automatic logic [7:0] wbyte(input logic [63:0] w, input logic [4:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx < 5'(WINDOW_BYTES)) begin
            b = w[{idx[2:0], 3'b000} +: 8];
        end
        return b;
    endfunction

endpackage

// ===== rtl/uld_cell.sv =====
// One ligature table cell: holds one entry, compares it with the lookup and
// exact-match keys and passes priority chains to its neighbour. Uses uld_pkg.
`timescale 1ns / 1ps
module uld_cell
    import uld_pkg::*;
#(
    parameter int MAX_LIG_LEN = MAX_LIG_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    input  logic      i_xseen,
    input  logic      i_lseen,
    input  t_hit      i_lacc,
    output t_entry    o_entry,
    output logic      o_xseen,
    output logic      o_lseen,
    output t_hit      o_lacc
);

    t_entry r_ent;
    t_entry n_ent;
    logic   w_lmatch;
    logic   w_xmatch;

    always_comb begin
        w_lmatch = r_ent.valid && (r_ent.text[7:0] == i_ctl.look[7:0]);
        for (int k = 1; k < 4; k++) begin
            if ((3'(k) < r_ent.len) && (k < MAX_LIG_LEN)
                && (r_ent.text[8*k +: 8] != i_ctl.look[8*k +: 8])) begin
                w_lmatch = 1'b0;
            end
        end
    end

    assign w_xmatch = r_ent.valid && i_ctl.len_ok && (r_ent.len == i_ctl.llen)
                      && (r_ent.text == i_ctl.text);
    assign o_xseen  = i_xseen | w_xmatch;
    assign o_lseen  = i_lseen | w_lmatch;
    assign o_lacc   = i_lseen ? i_lacc : (w_lmatch ? t_hit'{r_ent.len, r_ent.code} : i_lacc);
    assign o_entry  = r_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_ctl.commit) begin
            case (i_ctl.kind)
                K_CLEAR: n_ent.valid = 1'b0;
                K_ADD: begin
                    if (i_ctl.ins) begin
                        n_ent = i_prev;
                    end else if (w_xmatch) begin
                        n_ent.code = i_ctl.lout;
                    end
                end
                K_DEL: begin
                    if (o_xseen) begin
                        n_ent = i_next;
                    end
                end
                default: n_ent = r_ent;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent <= n_ent;
        end
    end

endmodule

// ===== rtl/utf8_ligature_decoder.sv =====
// Top level of the UTF-8 decoder with ligature table: stream handshake, the
// prefix walk, the row of table cells and the result register. Uses uld_pkg, uld_cell.
`timescale 1ns / 1ps
// Usage
// The block takes one item on the slave stream and returns exactly one result
// item on the master stream. The item kind travels in s_axis_tuser: decode,
// add ligature, delete ligature or clear the table. A decode item carries an
// eight-byte window and returns one character with the number of bytes used.
// In the accept cycle the window is masked and the bar and ZWNJ prefixes are
// walked; in the working stage every table cell then compares its entry in
// parallel, the first match along the cell row wins, and the result and any
// table update are committed together. A new item is accepted once the
// previous one has been committed, since the single working stage holds one
// item at a time. The result register lets the next item enter while a result
// still waits to be taken; if the receiver stalls, the working stage holds its
// item until the result register frees.
// Reset empties the table (all entries invalid) and clears both handshakes;
// no clearing pass is needed, so items are taken from the first cycle after reset.
module utf8_ligature_decoder
    import uld_pkg::*;
#(
    parameter int NUM_LIGS    = NUM_LIGS_DEF,
    parameter int MAX_LIG_LEN = MAX_LIG_LEN_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // window[63:0], window_len[67:64], ligs_enabled[68], lig_text[100:69],
    // lig_len[103:101], lig_out[119:104]
    input  logic [119:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // code_point[20:0], bytes_used[24:21], lig_hit[25], status[27:26], zero above
    output logic [31:0]  m_axis_tdata
);

    // Input field views.
    logic [63:0] w_win_in;
    logic [3:0]  w_wlen_in;
    logic [3:0]  w_wlen_eff;
    logic        w_ligs_in;
    logic [63:0] w_win_mask;
    logic [3:0]  w_pos;
    logic        w_zwnj;

    // Working stage.
    logic        r_busy;
    t_kind       r_kind;
    logic [63:0] r_win;
    logic [3:0]  r_wlen;
    logic        r_ligs;
    logic [3:0]  r_pos;
    logic [31:0] r_text;
    logic [2:0]  r_llen;
    logic [15:0] r_lout;

    // Result register.
    logic        r_ovalid;
    logic [20:0] r_code;
    logic [3:0]  r_used;
    logic        r_hit;
    t_status     r_status;
    logic [20:0] n_code;
    logic [3:0]  n_used;
    logic        n_hit;
    t_status     n_status;

    logic        w_accept;
    logic        w_commit;
    logic        w_len_ok;
    logic        w_full;
    logic [31:0] w_look;
    t_cell_ctl   w_ctl;
    t_entry      w_new;

    t_entry      w_ent   [NUM_LIGS];
    logic        w_xs    [NUM_LIGS+1];
    logic        w_ls    [NUM_LIGS+1];
    t_hit        w_lacc  [NUM_LIGS+1];
    logic [NUM_LIGS-1:0] w_vld;

    assign w_win_in  = s_axis_tdata[63:0];
    assign w_wlen_in = s_axis_tdata[67:64];
    assign w_ligs_in = s_axis_tdata[68];
    assign w_wlen_eff = (w_wlen_in > 4'(WINDOW_BYTES)) ? 4'(WINDOW_BYTES) : w_wlen_in;

    // Bytes at or beyond the valid length read as zero.
    always_comb begin
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            w_win_mask[8*i +: 8] = (4'(i) < w_wlen_eff) ? w_win_in[8*i +: 8] : 8'h00;
        end
    end

    // Prefix walk: single bars (with ligatures on) and the first ZWNJ are
    // skipped. Once the position passes the window the byte is zero and the
    // walk stops, so nine steps always suffice.
    always_comb begin
        logic       stop;
        logic [7:0] c;
        logic [7:0] c1;
        logic [7:0] c2;
        w_pos  = 4'd0;
        w_zwnj = 1'b0;
        stop   = 1'b0;
        for (int s = 0; s < WINDOW_BYTES + 1; s++) begin
            c  = wbyte(w_win_mask, {1'b0, w_pos});
            c1 = wbyte(w_win_mask, 5'(w_pos) + 5'd1);
            c2 = wbyte(w_win_mask, 5'(w_pos) + 5'd2);
            if (!stop) begin
                if (w_ligs_in && (c == BAR) && (c1 != BAR)) begin
                    w_pos = w_pos + 4'd1;
                end else if (!w_zwnj && (c == ZWNJ_B0) && (c1 == ZWNJ_B1)
                             && (c2 == ZWNJ_B2)) begin
                    w_zwnj = 1'b1;
                    w_pos  = w_pos + 4'd3;
                end else begin
                    stop = 1'b1;
                end
            end
        end
    end

    assign s_axis_tready = !r_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_commit      = r_busy && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_commit) begin
                r_busy <= 1'b0;
            end
        end
        if (w_accept) begin
            r_kind <= t_kind'(s_axis_tuser);
            r_win  <= w_win_mask;
            r_wlen <= w_wlen_eff;
            r_ligs <= w_ligs_in;
            r_pos  <= w_pos;
            r_llen <= s_axis_tdata[103:101];
            r_lout <= s_axis_tdata[119:104];
            // Source bytes past the ligature length are stored as zero.
            for (int k = 0; k < 4; k++) begin
                r_text[8*k +: 8] <= (3'(k) < s_axis_tdata[103:101])
                                    ? s_axis_tdata[69 + 8*k +: 8] : 8'h00;
            end
        end
    end

    // Window bytes at the decode position, broadcast to every cell.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_look[8*k +: 8] = wbyte(r_win, 5'(r_pos) + 5'(k));
        end
    end

    assign w_len_ok = (r_llen != 3'd0) && (r_llen <= 3'(MAX_LIG_LEN));
    assign w_full   = w_ent[NUM_LIGS-1].valid;
    assign w_new    = t_entry'{1'b1, r_llen, r_text, r_lout};

    always_comb begin
        w_ctl.kind   = r_kind;
        w_ctl.commit = w_commit;
        w_ctl.len_ok = w_len_ok;
        w_ctl.ins    = w_len_ok && !w_xs[NUM_LIGS] && !w_full;
        w_ctl.llen   = r_llen;
        w_ctl.text   = r_text;
        w_ctl.lout   = r_lout;
        w_ctl.look   = w_look;
    end

    assign w_xs[0]   = 1'b0;
    assign w_ls[0]   = 1'b0;
    assign w_lacc[0] = '0;

    // The row of table cells; entry 0 is the newest. Inserts shift towards
    // the back, deletes pull the later entries forward.
    for (genvar g = 0; g < NUM_LIGS; g++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        if (g == 0) begin : g_first
            assign w_prev = w_new;
        end else begin : g_mid
            assign w_prev = w_ent[g-1];
        end
        if (g == NUM_LIGS - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_ent[g+1];
        end
        uld_cell #(
            .MAX_LIG_LEN (MAX_LIG_LEN)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_xseen (w_xs[g]),
            .i_lseen (w_ls[g]),
            .i_lacc  (w_lacc[g]),
            .o_entry (w_ent[g]),
            .o_xseen (w_xs[g+1]),
            .o_lseen (w_ls[g+1]),
            .o_lacc  (w_lacc[g+1])
        );
        assign w_vld[g] = w_ent[g].valid;
    end

    // Character decode at the walked position.
    always_comb begin
        logic [7:0] c;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic [3:0] len;
        logic [4:0] used;
        logic       nested;
        logic       leadcont;
        c  = w_look[7:0];
        c1 = w_look[15:8];
        c2 = w_look[23:16];
        c3 = w_look[31:24];
        len      = 4'd1;
        nested   = 1'b0;
        leadcont = 1'b0;
        n_code   = 21'(c);
        n_hit    = 1'b0;
        n_used   = 4'd0;
        n_status = ST_OK;
        if (c <= ASCII_MAX) begin
            if (c inside {[TAG3_LO:TAG3_HI]}) begin
                len = 4'd3;
            end else if (c == TAG2) begin
                len = 4'd2;
            end else if (r_ligs && (c == BAR) && (c1 == BAR)) begin
                len = 4'd2;
            end else if (r_ligs && w_ls[NUM_LIGS] && (w_lacc[NUM_LIGS].code != 16'h0)) begin
                n_code = 21'(w_lacc[NUM_LIGS].code);
                len    = 4'(w_lacc[NUM_LIGS].len);
                n_hit  = 1'b1;
            end
        end else if (c < LEAD3_LO) begin
            leadcont = (c[7:6] == 2'b10);
            n_code   = 21'({c[4:0], c1[5:0]});
            len      = 4'd2;
        end else if (c < LEAD4_LO) begin
            len = 4'd3;
            if ((c == ZWNJ_B0) && (c1 == ZWNJ_B1) && (c2 == ZWNJ_B2)) begin
                nested = 1'b1;
                n_code = ZWNJ_CP;
            end else begin
                n_code = 21'({c[3:0], c1[5:0], c2[5:0]});
            end
        end else begin
            len    = 4'd4;
            n_code = {c[2:0], c1[5:0], c2[5:0], c3[5:0]};
        end
        used = 5'(r_pos) + 5'(len);
        if (nested) begin
            n_status = ST_BAD;
        end else if (leadcont) begin
            n_status = ST_LEADCONT;
        end else if (used > 5'(r_wlen)) begin
            n_status = ST_BAD;
        end
        n_used = (used > 5'(WINDOW_BYTES)) ? 4'(WINDOW_BYTES) : used[3:0];

        // Table items answer zeros, or table full for an add refused because the table is full.
        if (r_kind != K_DECODE) begin
            n_code   = 21'd0;
            n_used   = 4'd0;
            n_hit    = 1'b0;
            n_status = ST_OK;
            if ((r_kind == K_ADD) && w_len_ok && !w_xs[NUM_LIGS] && w_full) begin
                n_status = ST_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (w_commit) begin
            r_code   <= n_code;
            r_used   <= n_used;
            r_hit    <= n_hit;
            r_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0000, r_status, r_hit, r_used, r_code};

    // Valid entries always form a prefix of the table.
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_vld & (w_vld + 1'b1)) == '0))
        else $error("ligature table valid bits are not a prefix");

    // A committed item always shows up as a result in the next cycle.
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> m_axis_tvalid)
        else $error("committed item produced no result");

    // An accepted item occupies the working stage until it is committed.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_busy && !s_axis_tready))
        else $error("accepted item did not occupy the working stage");

    // A clear leaves the whole table empty.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (r_kind == K_CLEAR)) |=> (w_vld == '0))
        else $error("clear left valid entries");

endmodule

// ===== test/utf8_ligature_decoder_tb.sv =====
// Self-checking testbench for utf8_ligature_decoder: drives table and decode items on
// the slave stream and checks every result item against a behavioural predictor.
// Depends on uld_pkg and the utf8_ligature_decoder RTL.
`timescale 1ns / 1ps
module utf8_ligature_decoder_tb;
    import uld_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int HOLD_CYCLES = 150;

    typedef struct {
        logic [20:0] code_point;
        logic [3:0]  bytes_used;
        logic        lig_hit;
        logic [1:0]  status;
    } t_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // window[63:0], window_len[67:64], ligs_enabled[68], lig_text[100:69],
    // lig_len[103:101], lig_out[119:104]
    logic [119:0] s_axis_tdata;
    // kind[1:0]
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // code_point[20:0], bytes_used[24:21], lig_hit[25], status[27:26]
    logic [31:0]  m_axis_tdata;

    utf8_ligature_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the ligature table; entry 0 is the newest.
    logic [31:0] lig_text_tab [TABLE_DEPTH];
    logic [2:0]  lig_len_tab  [TABLE_DEPTH];
    logic [15:0] lig_code_tab [TABLE_DEPTH];
    int          lig_count;
    logic [7:0]  win_byte [8];

    t_result pending_results [$];
    int      mismatches;
    bit      calm;       // when set, neither side idles
    bit      hold_req;   // asks the receiver for a long hold-off

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic logic [7:0] wb(input int p);
        return (p >= 0 && p < 8) ? win_byte[p] : 8'h00;
    endfunction

    function automatic int find_exact(input logic [31:0] t, input logic [2:0] l);
        for (int i = 0; i < lig_count; i++) begin
            if (lig_len_tab[i] == l && lig_text_tab[i] == t) return i;
        end
        return -1;
    endfunction

    function automatic int match_at(input int p);
        bit ok;
        for (int i = 0; i < lig_count; i++) begin
            ok = (lig_text_tab[i][7:0] == wb(p));
            for (int k = 1; k < int'(lig_len_tab[i]) && k < 4; k++) begin
                if (lig_text_tab[i][8*k +: 8] != wb(p + k)) ok = 0;
            end
            if (ok) return i;
        end
        return -1;
    endfunction

    // Works out the result of one item and updates the shadow table.
    function automatic t_result decode_or_update(input t_kind k, input logic [119:0] d);
        t_result     r;
        logic [31:0] txt;
        logic [2:0]  ll;
        int          at, wl, pos, ln, e;
        bit          zw, nest, lc, done;
        logic [7:0]  c;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic [7:0]  c3;
        r = '{default: '0};
        ll = d[103:101];
        if (k == K_CLEAR) begin
            lig_count = 0;
        end else if (k == K_ADD || k == K_DEL) begin
            if (ll >= 1 && ll <= 4) begin
                txt = (ll == 4) ? d[100:69] : (d[100:69] & ((32'd1 << (8 * ll)) - 1));
                at = find_exact(txt, ll);
                if (k == K_ADD) begin
                    if (at >= 0) begin
                        lig_code_tab[at] = d[119:104];
                    end else if (lig_count >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int i = lig_count; i > 0; i--) begin
                            lig_text_tab[i] = lig_text_tab[i-1];
                            lig_len_tab[i]  = lig_len_tab[i-1];
                            lig_code_tab[i] = lig_code_tab[i-1];
                        end
                        lig_text_tab[0] = txt;
                        lig_len_tab[0]  = ll;
                        lig_code_tab[0] = d[119:104];
                        lig_count++;
                    end
                end else if (at >= 0) begin
                    for (int i = at; i + 1 < lig_count; i++) begin
                        lig_text_tab[i] = lig_text_tab[i+1];
                        lig_len_tab[i]  = lig_len_tab[i+1];
                        lig_code_tab[i] = lig_code_tab[i+1];
                    end
                    lig_count--;
                end
            end
        end else begin
            wl = (d[67:64] > 8) ? 8 : int'(d[67:64]);
            for (int i = 0; i < 8; i++) win_byte[i] = (i < wl) ? d[8*i +: 8] : 8'h00;
            pos = 0; ln = 0; zw = 0; nest = 0; lc = 0;
            for (int g = 0; g < 16; g++) begin
                c  = wb(pos);
                c1 = wb(pos + 1);
                c2 = wb(pos + 2);
                c3 = wb(pos + 3);
                done = 1;
                if (c <= ASCII_MAX) begin
                    if (c >= TAG3_LO && c <= TAG3_HI) begin
                        r.code_point = 21'(c); ln = 3;
                    end else if (c == TAG2) begin
                        r.code_point = 21'(c); ln = 2;
                    end else if (!d[68]) begin
                        r.code_point = 21'(c); ln = 1;
                    end else if (c == BAR && c1 == BAR) begin
                        r.code_point = 21'(BAR); ln = 2;
                    end else if (c == BAR) begin
                        pos++; done = 0;
                    end else begin
                        e = match_at(pos);
                        if (e >= 0 && lig_code_tab[e] != 0) begin
                            r.code_point = 21'(lig_code_tab[e]);
                            ln = int'(lig_len_tab[e]);
                            r.lig_hit = 1'b1;
                        end else begin
                            r.code_point = 21'(c); ln = 1;
                        end
                    end
                end else if (c < LEAD3_LO) begin
                    if (c[7:6] == 2'b10) lc = 1;
                    r.code_point = 21'({c[4:0], c1[5:0]});
                    ln = 2;
                end else if (c < LEAD4_LO) begin
                    if (c == ZWNJ_B0 && c1 == ZWNJ_B1 && c2 == ZWNJ_B2) begin
                        if (!zw) begin
                            zw = 1; pos += 3; done = 0;
                        end else begin
                            nest = 1; r.code_point = ZWNJ_CP; ln = 3;
                        end
                    end else begin
                        r.code_point = 21'({c[3:0], c1[5:0], c2[5:0]});
                        ln = 3;
                    end
                end else begin
                    r.code_point = {c[2:0], c1[5:0], c2[5:0], c3[5:0]};
                    ln = 4;
                end
                if (done) break;
            end
            pos += ln;
            if (nest) r.status = ST_BAD;
            else if (lc) r.status = ST_LEADCONT;
            else if (pos > wl) r.status = ST_BAD;
            r.bytes_used = (pos > 8) ? 4'd8 : 4'(pos);
        end
        return r;
    endfunction

    function automatic logic [119:0] pack(input logic [63:0] w, input logic [3:0] wl,
                                          input logic en, input logic [31:0] t,
                                          input logic [2:0] ll, input logic [15:0] o);
        return {o, ll, t, en, wl, w};
    endfunction

    // Offers one item, idling now and then, and records its expected result once taken.
    task automatic send_item(input t_kind k, input logic [119:0] d);
        if (!calm && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(decode_or_update(k, d));
    endtask

    task automatic decode(input logic [63:0] w, input logic [3:0] wl, input logic en);
        send_item(K_DECODE, pack(w, wl, en, $urandom, 3'($urandom), 16'($urandom)));
    endtask

    task automatic table_op(input t_kind k, input logic [31:0] t, input logic [2:0] ll,
                            input logic [15:0] o);
        send_item(k, pack({$urandom, $urandom}, 4'($urandom), 1'($urandom), t, ll, o));
    endtask

    // Stops offering items until every expected result has come back.
    task automatic drain();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Receiver: random stalls, and a long hold-off on request.
    int hold_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end else begin
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 7);
            end
        end
    end

    // Result checker: compares each taken result item with the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: %h", m_axis_tdata);
                mismatches++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata[20:0] !== exp_r.code_point) begin
                    $error("code_point expected %h got %h", exp_r.code_point,
                           m_axis_tdata[20:0]);
                    mismatches++;
                end
                if (m_axis_tdata[24:21] !== exp_r.bytes_used) begin
                    $error("bytes_used expected %0d got %0d", exp_r.bytes_used,
                           m_axis_tdata[24:21]);
                    mismatches++;
                end
                if (m_axis_tdata[25] !== exp_r.lig_hit) begin
                    $error("lig_hit expected %b got %b", exp_r.lig_hit, m_axis_tdata[25]);
                    mismatches++;
                end
                if (m_axis_tdata[27:26] !== exp_r.status) begin
                    $error("status expected %0d got %0d", exp_r.status, m_axis_tdata[27:26]);
                    mismatches++;
                end
            end
        end
    end

    // Extremes and every special case of the decoder.
    task automatic test_directed();
        decode(64'h0, 4'd0, 1'b1);
        decode(64'hffff_ffff_ffff_ffff, 4'd15, 1'b0);
        decode(64'h0000_0000_0000_9f17, 4'd8, 1'b1);      // three-byte tag code
        decode(64'h0000_0000_0000_411f, 4'd2, 1'b0);      // two-byte tag code
        decode(64'h0000_0000_0000_7c7c, 4'd2, 1'b1);      // bar escape
        decode(64'h0000_0000_0000_417c, 4'd2, 1'b1);      // single bar prefix
        decode(64'h0000_0000_0000_417c, 4'd2, 1'b0);
        decode(64'h0000_0041_8c80_e27c, 4'd8, 1'b1);      // bar then ZWNJ
        decode(64'h0000_8c80_e28c_80e2, 4'd8, 1'b1);      // nested ZWNJ
        decode(64'h0000_0000_0000_85a5, 4'd2, 1'b1);      // lead continuation byte
        decode(64'h0000_0000_00bf_a5f0, 4'd4, 1'b1);
        decode(64'h0000_0000_8081_82ff, 4'd3, 1'b1);      // lead 0xf8 up, short window
        decode(64'h0000_0000_0000_a0e1, 4'd2, 1'b1);
        table_op(K_ADD, 32'hffff_6261, 3'd2, 16'h0);      // zero code entry
        table_op(K_ADD, 32'h0000_0061, 3'd1, 16'hffff);
        decode(64'h0000_0000_0000_6261, 4'd8, 1'b1);      // newer one-byte entry wins
        decode(64'h0000_0000_0000_6361, 4'd8, 1'b1);
        decode(64'h0000_0000_0000_6361, 4'd8, 1'b0);
        table_op(K_ADD, 32'h6463_6261, 3'd0, 16'h1234);   // bad length
        table_op(K_ADD, 32'h6463_6261, 3'd7, 16'h1234);
        table_op(K_DEL, 32'h6463_6261, 3'd5, 16'h0);
        table_op(K_DEL, 32'h0000_6261, 3'd2, 16'h0);
        decode(64'h0000_0000_0000_6261, 4'd1, 1'b1);
        table_op(K_CLEAR, 32'h0, 3'd0, 16'h0);
        drain();
    endtask

    // Fills the table, refuses one more, replaces an entry while full.
    task automatic test_full_table();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            table_op(K_ADD, 32'(32'h4000 + i), 3'd2, 16'(16'h100 + i));
        end
        table_op(K_ADD, 32'h7777_7777, 3'd4, 16'h5555);
        table_op(K_ADD, 32'h4005, 3'd2, 16'hbeef);
        decode(64'h0000_0000_0000_4005, 4'd8, 1'b1);
        table_op(K_DEL, 32'h401f, 3'd2, 16'h0);
        table_op(K_ADD, 32'h7777_7777, 3'd4, 16'h5555);
        decode(64'h0000_0000_7777_7777, 4'd8, 1'b1);
        table_op(K_CLEAR, 32'h0, 3'd0, 16'h0);
        drain();
    endtask

    // Receiver holds off while items keep coming, so the block backs up.
    task automatic test_backpressure();
        hold_req = 1;
        for (int i = 0; i < 20; i++) decode({$urandom, $urandom}, 4'($urandom), 1'($urandom));
        drain();
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return BAR;
            1: return 8'(8'h61 + $urandom_range(0, 3));
            2: return 8'(8'h17 + $urandom_range(0, 8));
            3: return ZWNJ_B0;
            4: return ZWNJ_B1;
            5: return ZWNJ_B2;
            6: return 8'(8'h80 + $urandom_range(0, 127));
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed text: table updates over a small alphabet, decodes
    // of windows built from ligature texts, prefixes and assorted UTF-8.
    task automatic test_random();
        logic [63:0] w;
        logic [31:0] t;
        int          n, p, e;
        for (int it = 0; it < 1050; it++) begin
            calm = (it >= 300 && it < 450);
            n = $urandom_range(0, 99);
            t = {4{8'h61 + 8'($urandom_range(0, 3))}}
                ^ {16'h0, 8'($urandom_range(0, 3)), 8'h0}
                ^ {8'h0, 8'($urandom_range(0, 3)), 16'h0};
            if (n < 1) begin
                table_op(K_CLEAR, $urandom, 3'($urandom), 16'($urandom));
            end else if (n < 12) begin
                table_op(K_ADD, ($urandom_range(0, 9) == 0) ? $urandom : t,
                         ($urandom_range(0, 19) == 0) ? 3'($urandom)
                                                       : 3'($urandom_range(1, 4)),
                         ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom));
            end else if (n < 17) begin
                e = (lig_count > 0) ? $urandom_range(0, lig_count - 1) : 0;
                if (lig_count > 0 && $urandom_range(0, 1))
                    table_op(K_DEL, lig_text_tab[e], lig_len_tab[e], 16'($urandom));
                else
                    table_op(K_DEL, t, 3'($urandom_range(0, 7)), 16'($urandom));
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    w = {$urandom, $urandom};
                end else begin
                    for (int i = 0; i < 8; i++) w[8*i +: 8] = pick_byte();
                    p = 0;
                    if ($urandom_range(0, 3) == 0) begin
                        w[7:0] = BAR; p = 1;
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        w[8*p +: 24] = {ZWNJ_B2, ZWNJ_B1, ZWNJ_B0}; p += 3;
                        if ($urandom_range(0, 3) == 0) begin
                            w[8*p +: 24] = {ZWNJ_B2, ZWNJ_B1, ZWNJ_B0}; p += 3;
                        end
                    end
                    if (lig_count > 0 && p < 5 && $urandom_range(0, 1)) begin
                        e = $urandom_range(0, lig_count - 1);
                        w[8*p +: 32] = lig_text_tab[e];
                    end
                end
                decode(w, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd8,
                       $urandom_range(0, 4) != 0);
            end
        end
        calm = 0;
        drain();
    endtask

    initial begin
        mismatches    = 0;
        lig_count     = 0;
        calm          = 0;
        hold_req      = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = K_DECODE;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        test_backpressure();
        test_random();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("utf8_ligature_decoder_tb OK");
        end else begin
            $display("utf8_ligature_decoder_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("utf8_ligature_decoder_tb NOT OK");
        $finish;
    end

endmodule

// ===== utf8_ligature_decoder.f =====
rtl/uld_pkg.sv
rtl/uld_cell.sv
rtl/utf8_ligature_decoder.sv
test/utf8_ligature_decoder_tb.sv
